// File: hw/rtl/hhfr_pkg.sv
// Shared types, constants and helper functions for the HTTP header field recognizer.
// Used by hhfr_name_match, hhfr_num_parse and http_header_field_recognizer.
// Depends on nothing.
package hhfr_pkg;

  localparam int unsigned NameCount = 12;
  localparam int unsigned NameMaxLen = 19;

  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChVt = 8'h0B;
  localparam logic [7:0] ChFf = 8'h0C;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5A;

  localparam logic [3:0] HdrContentLength = 4'd0;
  localparam logic [3:0] HdrStatus = 4'd8;

  // Names are held right-justified in a fixed-width vector, first character highest.
  localparam logic [NameMaxLen*8-1:0] NAME_STR [NameCount] = '{
    "content-length: ", "content-type: ", "user-agent: ",
    "if-modified-since: ", "authorization: ", "referer: ",
    "cookie: ", "location: ", "status: ", "range: ",
    "connection: ", "transfer-encoding: "
  };
  localparam logic [4:0] NAME_LEN [NameCount] = '{
    5'd16, 5'd14, 5'd12, 5'd19, 5'd15, 5'd9, 5'd8, 5'd10, 5'd8, 5'd7, 5'd12, 5'd19
  };

  typedef enum logic [1:0] {
    MODE_NAME  = 2'd0,
    MODE_VALUE = 2'd1,
    MODE_SKIP  = 2'd2
  } line_mode_e;

  typedef enum logic [1:0] {
    PH_BLANKS = 2'd0,
    PH_SIGNED = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } num_phase_e;

  typedef struct packed {
    num_phase_e  phase;
    logic        negative;
    logic        clamped;
    logic [31:0] acc;
  } num_state_t;

  typedef struct packed {
    logic [NameCount-1:0] alive;
    logic                 hit;
    logic [3:0]           hit_id;
  } name_match_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    fold_case = (c >= ChUpperA && c <= ChUpperZ) ? c + 8'd32 : c;
  endfunction

  // Character of name k at position idx, zero past the end of the name.
  function automatic logic [7:0] name_char(input logic [3:0] k, input logic [4:0] idx);
    logic [4:0] len;
    logic [4:0] pos;
    len = NAME_LEN[k];
    pos = len - 5'd1 - idx;
    if (idx >= len) begin
      name_char = 8'h00;
    end else begin
      name_char = NAME_STR[k][8*pos +: 8];
    end
  endfunction

endpackage

// File: hw/rtl/hhfr_name_match.sv
// Compares one header byte against all twelve header names in parallel.
// Depends on hhfr_pkg for the name table and the match result struct.
module hhfr_name_match (
  input  logic [7:0]                      byte_i,
  input  logic                            final_byte_i,
  input  logic [hhfr_pkg::NameCount-1:0]  alive_i,
  input  logic [4:0]                      idx_i,
  output hhfr_pkg::name_match_t           match_o
);

  logic [7:0] folded;

  assign folded = hhfr_pkg::fold_case(byte_i);

  always_comb begin
    match_o = '0;
    for (int k = 0; k < hhfr_pkg::NameCount; k++) begin
      match_o.alive[k] = alive_i[k] && (idx_i < hhfr_pkg::NAME_LEN[k]) &&
                         (folded == hhfr_pkg::name_char(4'(k), idx_i));
    end
    // A name completes on its last character, unless that byte ends the block.
    for (int k = 0; k < hhfr_pkg::NameCount; k++) begin
      if (match_o.alive[k] && (hhfr_pkg::NAME_LEN[k] == idx_i + 5'd1) && !final_byte_i) begin
        match_o.hit    = 1'b1;
        match_o.hit_id = 4'(k);
      end
    end
  end

endmodule

// File: hw/rtl/hhfr_num_parse.sv
// Next state of the decimal value parser for one value byte.
// Depends on hhfr_pkg for the parser state struct and character constants.
module hhfr_num_parse (
  input  logic [7:0]           byte_i,
  input  hhfr_pkg::num_state_t state_i,
  output hhfr_pkg::num_state_t state_o
);

  logic        is_digit;
  logic        is_blank;
  logic        is_sign;
  logic [35:0] times_ten;
  logic [35:0] sum;

  assign is_digit = (byte_i >= hhfr_pkg::ChZero) && (byte_i <= hhfr_pkg::ChNine);
  assign is_blank = (byte_i == hhfr_pkg::ChSpace) || (byte_i == hhfr_pkg::ChTab) ||
                    (byte_i == hhfr_pkg::ChVt) || (byte_i == hhfr_pkg::ChFf) ||
                    (byte_i == hhfr_pkg::ChCr);
  assign is_sign  = (byte_i == hhfr_pkg::ChPlus) || (byte_i == hhfr_pkg::ChMinus);

  // Ten times the accumulator as two shifted copies.
  assign times_ten = {1'b0, state_i.acc, 3'b000} + {3'b000, state_i.acc, 1'b0};
  assign sum       = times_ten + {32'd0, 4'(byte_i - hhfr_pkg::ChZero)};

  always_comb begin
    state_o = state_i;
    unique case (state_i.phase)
      hhfr_pkg::PH_BLANKS: begin
        if (is_blank) begin
          state_o.phase = hhfr_pkg::PH_BLANKS;
        end else if (is_sign) begin
          state_o.negative = (byte_i == hhfr_pkg::ChMinus);
          state_o.phase    = hhfr_pkg::PH_SIGNED;
        end else begin
          state_o.phase = is_digit ? hhfr_pkg::PH_DIGITS : hhfr_pkg::PH_DONE;
        end
      end
      hhfr_pkg::PH_SIGNED: begin
        state_o.phase = is_digit ? hhfr_pkg::PH_DIGITS : hhfr_pkg::PH_DONE;
      end
      hhfr_pkg::PH_DIGITS: begin
        if (!is_digit) begin
          state_o.phase = hhfr_pkg::PH_DONE;
        end
      end
      default: begin
        state_o.phase = hhfr_pkg::PH_DONE;
      end
    endcase
    if (state_o.phase == hhfr_pkg::PH_DIGITS) begin
      if (sum[35:32] != 4'd0) begin
        state_o.clamped = 1'b1;
      end
      state_o.acc = state_o.clamped ? 32'hFFFF_FFFF : sum[31:0];
    end
  end

endmodule

// File: hw/rtl/http_header_field_recognizer.sv
// Top level of the HTTP header field recognizer: input register, line state and result register.
// Depends on hhfr_pkg, hhfr_name_match and hhfr_num_parse.

// The block takes one header byte per word and can accept a word in every cycle while it
// is not stalled; the result of a matched line is registered when the byte that ends it
// (its newline, or the final byte of the block) moves on from the one input register into
// the one result register. All per-byte work (twelve name comparators, the decimal step
// and the length subtraction) happens between them. A stall on the result side holds the
// pipeline only while the result register is full. Byte offsets wrap after
// BLOCK_BYTES-1, and all line state returns to reset after a word flagged final.
module http_header_field_recognizer #(
  parameter int unsigned BLOCK_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_in_i,
  input  logic        final_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  header_id_o,
  output logic [15:0] value_start_o,
  output logic [15:0] value_length_o,
  output logic [31:0] number_value_o,
  output logic        number_valid_o,
  output logic        number_saturated_o
);

  localparam int unsigned PW = $clog2(BLOCK_BYTES);
  localparam logic [PW-1:0] LastPos = PW'(BLOCK_BYTES - 1);
  localparam logic [PW:0] BlockSize = (PW+1)'(BLOCK_BYTES);

  // Input register.
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       final_q;
  logic       advance;

  // Line state.
  logic [PW-1:0]                     pos_q, pos_d;
  logic [hhfr_pkg::NameCount-1:0]    alive_q, alive_d, alive_n;
  logic [4:0]                        idx_q, idx_d, idx_n;
  hhfr_pkg::line_mode_e              mode_q, mode_d, mode_n;
  logic [3:0]                        matched_q, matched_d, matched_n;
  logic [PW-1:0]                     vbegin_q, vbegin_d, vbegin_n;
  logic                              prev_cr_q, prev_cr_d;
  hhfr_pkg::num_state_t              num_q, num_d, num_n, num_step;

  // Result register.
  logic        out_valid_q;
  logic [3:0]  hdr_q;
  logic [15:0] vstart_q;
  logic [15:0] vlen_q;
  logic [31:0] nval_q;
  logic        nvalid_q;
  logic        nsat_q;

  hhfr_pkg::name_match_t match;

  logic          newline;
  logic          is_cr;
  logic [PW-1:0] pos_next;
  logic          emit;
  logic [PW-1:0] line_end;
  logic [PW:0]   span;
  logic [PW-1:0] len_raw;
  logic [PW-1:0] len_fix;
  logic          cr_last;
  logic          is_num_hdr;
  logic [31:0]   num_out;

  hhfr_name_match u_name_match (
    .byte_i       (byte_q),
    .final_byte_i (final_q),
    .alive_i      (alive_q),
    .idx_i        (idx_q),
    .match_o      (match)
  );

  hhfr_num_parse u_num_parse (
    .byte_i  (byte_q),
    .state_i (num_q),
    .state_o (num_step)
  );

  // The held byte moves on unless the result register is full and stalled.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  assign newline  = (byte_q == hhfr_pkg::ChLf);
  assign is_cr    = (byte_q == hhfr_pkg::ChCr);
  assign pos_next = (pos_q == LastPos) ? '0 : pos_q + 1'b1;

  always_comb begin
    alive_n   = alive_q;
    idx_n     = idx_q;
    mode_n    = mode_q;
    matched_n = matched_q;
    vbegin_n  = vbegin_q;
    num_n     = num_q;
    unique case (mode_q)
      hhfr_pkg::MODE_NAME: begin
        if (!newline) begin
          alive_n = match.alive;
          idx_n   = idx_q + 5'd1;
          if (match.alive == '0) begin
            mode_n = hhfr_pkg::MODE_SKIP;
          end else if (match.hit) begin
            matched_n = match.hit_id;
            mode_n    = hhfr_pkg::MODE_VALUE;
            vbegin_n  = pos_next;
          end
        end
      end
      hhfr_pkg::MODE_VALUE: begin
        if (!newline) begin
          num_n = num_step;
        end
      end
      hhfr_pkg::MODE_SKIP: begin
        mode_n = hhfr_pkg::MODE_SKIP;
      end
      default: begin
        mode_n = hhfr_pkg::MODE_SKIP;
      end
    endcase
  end

  // Result of the line that this byte closes.
  assign emit     = (mode_n == hhfr_pkg::MODE_VALUE) && (newline || final_q);
  assign line_end = newline ? pos_q : pos_next;
  assign span     = {1'b0, line_end} + ((line_end < vbegin_n) ? BlockSize : '0) -
                    {1'b0, vbegin_n};
  assign len_raw  = span[PW-1:0];
  assign cr_last  = newline ? prev_cr_q : is_cr;
  assign len_fix  = (cr_last && (len_raw != '0)) ? len_raw - 1'b1 : len_raw;
  assign is_num_hdr = (matched_n == hhfr_pkg::HdrContentLength) ||
                      (matched_n == hhfr_pkg::HdrStatus);
  assign num_out  = num_n.clamped ? 32'hFFFF_FFFF :
                    (num_n.negative ? 32'd0 - num_n.acc : num_n.acc);

  always_comb begin
    pos_d     = pos_next;
    alive_d   = alive_n;
    idx_d     = idx_n;
    mode_d    = mode_n;
    matched_d = matched_n;
    vbegin_d  = vbegin_n;
    num_d     = num_n;
    prev_cr_d = is_cr;
    if (final_q) begin
      pos_d     = '0;
      vbegin_d  = '0;
      prev_cr_d = 1'b0;
    end
    if (final_q || newline) begin
      alive_d   = '1;
      idx_d     = '0;
      mode_d    = hhfr_pkg::MODE_NAME;
      matched_d = '0;
      num_d     = '{phase: hhfr_pkg::PH_BLANKS, negative: 1'b0, clamped: 1'b0, acc: 32'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q  <= byte_in_i;
      final_q <= final_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      alive_q   <= '1;
      idx_q     <= '0;
      mode_q    <= hhfr_pkg::MODE_NAME;
      matched_q <= '0;
      vbegin_q  <= '0;
      prev_cr_q <= 1'b0;
      num_q     <= '{phase: hhfr_pkg::PH_BLANKS, negative: 1'b0, clamped: 1'b0, acc: 32'd0};
    end else if (advance) begin
      pos_q     <= pos_d;
      alive_q   <= alive_d;
      idx_q     <= idx_d;
      mode_q    <= mode_d;
      matched_q <= matched_d;
      vbegin_q  <= vbegin_d;
      prev_cr_q <= prev_cr_d;
      num_q     <= num_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      hdr_q    <= matched_n;
      vstart_q <= 16'(vbegin_n);
      vlen_q   <= 16'(len_fix);
      nval_q   <= is_num_hdr ? num_out : 32'd0;
      nvalid_q <= is_num_hdr;
      nsat_q   <= is_num_hdr && num_n.clamped;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign header_id_o        = hdr_q;
  assign value_start_o      = vstart_q;
  assign value_length_o     = vlen_q;
  assign number_value_o     = nval_q;
  assign number_valid_o     = nvalid_q;
  assign number_saturated_o = nsat_q;

`ifndef SYNTHESIS
  a_num_valid_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (number_valid_o ==
      ((header_id_o == hhfr_pkg::HdrContentLength) || (header_id_o == hhfr_pkg::HdrStatus))))
    else $error("number_valid disagrees with header_id");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && number_saturated_o) |-> (number_valid_o && (number_value_o == 32'hFFFF_FFFF)))
    else $error("saturated number is not all ones");

  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked result");

  a_line_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((mode_q == hhfr_pkg::MODE_NAME) && (idx_q == 5'd0)) |-> (alive_q == '1))
    else $error("name match starts with names missing");

  a_matched_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == hhfr_pkg::MODE_VALUE) |-> (matched_q < 4'(hhfr_pkg::NameCount)))
    else $error("matched header out of range");
`endif

endmodule

// File: tb/sv/http_header_field_recognizer_tb.sv
// Self-checking testbench for http_header_field_recognizer: header bytes go in, line results come out.
// Depends on hhfr_pkg and the RTL of the block. A built-in line scanner predicts every result,
// and a monitor compares each accepted result with the oldest prediction.
module http_header_field_recognizer_tb;

  typedef struct {
    logic [3:0]  hdr;
    logic [15:0] start;
    logic [15:0] len;
    logic [31:0] num;
    logic        num_ok;
    logic        sat;
  } field_rpt_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  byte_in_i;
  logic        final_byte_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  header_id_o;
  logic [15:0] value_start_o;
  logic [15:0] value_length_o;
  logic [31:0] number_value_o;
  logic        number_valid_o;
  logic        number_saturated_o;

  string hdr_text [12] = '{
    "content-length: ", "content-type: ", "user-agent: ",
    "if-modified-since: ", "authorization: ", "referer: ",
    "cookie: ", "location: ", "status: ", "range: ",
    "connection: ", "transfer-encoding: "
  };

  // Scanner state, one copy of what the block keeps per header block.
  logic [15:0]          scan_pos;
  logic [11:0]          scan_alive;
  logic [4:0]           scan_idx;
  hhfr_pkg::line_mode_e scan_mode;
  logic [3:0]           scan_hdr;
  logic [15:0]          scan_vbeg;
  logic                 scan_prev_cr;
  logic [31:0]          num_acc;
  hhfr_pkg::num_phase_e num_phase;
  logic                 num_neg;
  logic                 num_clamp;

  field_rpt_t  pending_fields [$];
  field_rpt_t  want;
  logic [7:0]  line_q [$];
  bit          calm;
  int          failures;
  int          bytes_sent;

  http_header_field_recognizer i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .byte_in_i          (byte_in_i),
    .final_byte_i       (final_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .header_id_o        (header_id_o),
    .value_start_o      (value_start_o),
    .value_length_o     (value_length_o),
    .number_value_o     (number_value_o),
    .number_valid_o     (number_valid_o),
    .number_saturated_o (number_saturated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic clear_line();
    scan_alive = '1;
    scan_idx   = '0;
    scan_mode  = hhfr_pkg::MODE_NAME;
    scan_hdr   = '0;
    num_acc    = '0;
    num_phase  = hhfr_pkg::PH_BLANKS;
    num_neg    = 1'b0;
    num_clamp  = 1'b0;
  endtask

  task automatic clear_block();
    scan_pos     = '0;
    scan_vbeg    = '0;
    scan_prev_cr = 1'b0;
    clear_line();
  endtask

  // Advances the scanner by one accepted word and queues the result that it ends, if any.
  task automatic scan_byte(input logic [7:0] c, input logic fin);
    logic [11:0] hit;
    logic [7:0]  lc;
    logic [15:0] line_end;
    logic [15:0] span;
    logic        cr_last;
    logic        digit;
    logic        blank;
    logic        take;
    logic [63:0] wide;
    field_rpt_t  r;
    lc = (c >= hhfr_pkg::ChUpperA && c <= hhfr_pkg::ChUpperZ) ? c + 8'd32 : c;
    digit = (c >= hhfr_pkg::ChZero && c <= hhfr_pkg::ChNine);
    blank = (c == hhfr_pkg::ChSpace || c == hhfr_pkg::ChTab || c == hhfr_pkg::ChVt ||
             c == hhfr_pkg::ChFf || c == hhfr_pkg::ChCr);
    take = 1'b0;
    if (scan_mode == hhfr_pkg::MODE_NAME && c != hhfr_pkg::ChLf) begin
      hit = '0;
      for (int k = 0; k < 12; k++) begin
        if (scan_alive[k] && scan_idx < hdr_text[k].len() && lc == 8'(hdr_text[k][scan_idx])) begin
          hit[k] = 1'b1;
        end
      end
      scan_alive = hit;
      if (hit == '0) begin
        scan_mode = hhfr_pkg::MODE_SKIP;
      end else begin
        for (int k = 0; k < 12; k++) begin
          if (hit[k] && hdr_text[k].len() == scan_idx + 1 && !fin) begin
            scan_hdr  = 4'(k);
            scan_mode = hhfr_pkg::MODE_VALUE;
            scan_vbeg = scan_pos + 16'd1;
          end
        end
      end
      scan_idx = scan_idx + 5'd1;
    end else if (scan_mode == hhfr_pkg::MODE_VALUE && c != hhfr_pkg::ChLf) begin
      case (num_phase)
        hhfr_pkg::PH_BLANKS: begin
          if (!blank) begin
            if (c == hhfr_pkg::ChPlus || c == hhfr_pkg::ChMinus) begin
              num_neg   = (c == hhfr_pkg::ChMinus);
              num_phase = hhfr_pkg::PH_SIGNED;
            end else if (digit) begin
              num_phase = hhfr_pkg::PH_DIGITS;
              take = 1'b1;
            end else begin
              num_phase = hhfr_pkg::PH_DONE;
            end
          end
        end
        hhfr_pkg::PH_SIGNED: begin
          if (digit) begin
            num_phase = hhfr_pkg::PH_DIGITS;
            take = 1'b1;
          end else begin
            num_phase = hhfr_pkg::PH_DONE;
          end
        end
        hhfr_pkg::PH_DIGITS: begin
          if (digit) take = 1'b1;
          else num_phase = hhfr_pkg::PH_DONE;
        end
        default: ;
      endcase
      if (take) begin
        wide = {32'd0, num_acc} * 64'd10 + 64'(c - hhfr_pkg::ChZero);
        if (wide > 64'hFFFF_FFFF) num_clamp = 1'b1;
        num_acc = num_clamp ? 32'hFFFF_FFFF : wide[31:0];
      end
    end

    if (scan_mode == hhfr_pkg::MODE_VALUE && (c == hhfr_pkg::ChLf || fin)) begin
      line_end = (c == hhfr_pkg::ChLf) ? scan_pos : scan_pos + 16'd1;
      cr_last  = (c == hhfr_pkg::ChLf) ? scan_prev_cr : (c == hhfr_pkg::ChCr);
      // Offsets are 16 bits wide, so a value that crosses the wrap still subtracts right.
      span = line_end - scan_vbeg;
      if (cr_last && span != 16'd0) span = span - 16'd1;
      r.hdr    = scan_hdr;
      r.start  = scan_vbeg;
      r.len    = span;
      r.num    = '0;
      r.num_ok = 1'b0;
      r.sat    = 1'b0;
      if (scan_hdr == hhfr_pkg::HdrContentLength || scan_hdr == hhfr_pkg::HdrStatus) begin
        r.num_ok = 1'b1;
        r.sat    = num_clamp;
        r.num    = num_clamp ? 32'hFFFF_FFFF : (num_neg ? 32'd0 - num_acc : num_acc);
      end
      pending_fields.push_back(r);
    end

    scan_prev_cr = (c == hhfr_pkg::ChCr);
    if (fin) begin
      clear_block();
    end else begin
      scan_pos = scan_pos + 16'd1;
      if (c == hhfr_pkg::ChLf) clear_line();
    end
  endtask

  // Offers one word and returns once it has been accepted. Valid stays high between
  // words unless an idle cycle is drawn, so it is never dropped and raised in one step.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    logic stalled;
    if (!calm) begin
      while ($urandom_range(99) < 17) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i   <= 1'b1;
    byte_in_i    <= b;
    final_byte_i <= fin;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    bytes_sent++;
    scan_byte(b, fin);
  endtask

  task automatic send_line(input bit fin_last);
    for (int i = 0; i < line_q.size(); i++) begin
      send_byte(line_q[i], fin_last && i == line_q.size() - 1);
    end
    line_q.delete();
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(8'(s[i]));
  endtask

  // Style 0 keeps the name lower case, 1 mixes the case at random, 2 makes it upper case.
  task automatic push_name(input int k, input int style);
    logic [7:0] ch;
    for (int i = 0; i < hdr_text[k].len(); i++) begin
      ch = 8'(hdr_text[k][i]);
      if (ch >= 8'h61 && ch <= 8'h7A && (style == 2 || (style == 1 && $urandom_range(1) == 1))) begin
        ch = ch - 8'd32;
      end
      line_q.push_back(ch);
    end
  endtask

  task automatic test_each_name();
    for (int k = 0; k < 12; k++) begin
      push_name(k, k % 3);
      if (k == hhfr_pkg::HdrContentLength) push_text("  -123");
      else if (k == hhfr_pkg::HdrStatus) push_text("+4294967295");
      else begin
        push_text("value-");
        line_q.push_back(8'h61 + 8'(k));
      end
      push_text("\r\n");
      send_line(k == 11);
    end
  endtask

  task automatic test_number_parse();
    string nums [11] = '{
      "4294967295", "4294967296", "99999999999999", "-", "-0", "+", "abc", "",
      "00000000000000000001", "-2147483648", " \t\r 42x7"
    };
    for (int i = 0; i < 11; i++) begin
      push_name((i % 2 == 1) ? int'(hhfr_pkg::HdrStatus) : int'(hhfr_pkg::HdrContentLength), 1);
      push_text(nums[i]);
      push_text("\r\n");
      send_line(1'b0);
    end
    // Vertical tab and form feed count as blanks too.
    push_name(hhfr_pkg::HdrStatus, 0);
    line_q.push_back(hhfr_pkg::ChVt);
    line_q.push_back(hhfr_pkg::ChFf);
    push_text("-17 9\n");
    send_line(1'b1);
  endtask

  task automatic test_line_cases();
    push_text("\n");
    push_text("\r\n");
    push_text("X-Status: 5\r\n");
    push_text("Content-Type: \n");
    push_text("Range: \r\n");
    push_text("Refer: x\n");
    push_text("CONTENT-LENGTH:5\n");
    push_name(6, 0);
    line_q.push_back(8'h00);
    line_q.push_back(8'hFF);
    push_text("\r\n");
    line_q.push_back(8'hFF);
    push_text("Status: 1\n");
    line_q.push_back(8'h00);
    push_text("Status: 2\n");
    push_text("Content-Length: 12 34\r\r\n");
    send_line(1'b0);
    // Block ends on a carriage return inside the value.
    push_text("Location: /a\r");
    send_line(1'b1);
    // Block ends on the last character of a name, then inside a name.
    push_text("Status: ");
    send_line(1'b1);
    push_text("Cont");
    send_line(1'b1);
    push_text("Connection: keep\n");
    send_line(1'b1);
    push_text("Transfer-Encoding: chunked");
    send_line(1'b1);
    push_text("\n");
    send_line(1'b1);
  endtask

  task automatic test_random_blocks(input int byte_goal);
    logic [7:0] blanks [5] = '{hhfr_pkg::ChSpace, hhfr_pkg::ChTab, hhfr_pkg::ChVt,
                               hhfr_pkg::ChFf, hhfr_pkg::ChCr};
    int         first;
    int         pick;
    int         k;
    int         sel;
    int         cut;
    bit         fin_now;
    first = bytes_sent;
    while (bytes_sent - first < byte_goal) begin
      // A long stretch in the middle runs without any idle or stall cycle.
      calm = (bytes_sent - first >= 300) && (bytes_sent - first < 700);
      fin_now = ($urandom_range(99) < 6);
      pick = $urandom_range(99);
      k = $urandom_range(11);
      if (pick < 70) begin
        push_name(k, 1);
        if (k == hhfr_pkg::HdrContentLength || k == hhfr_pkg::HdrStatus ||
            $urandom_range(3) == 0) begin
          repeat ($urandom_range(2)) line_q.push_back(blanks[$urandom_range(4)]);
          sel = $urandom_range(9);
          if (sel == 0) line_q.push_back(hhfr_pkg::ChPlus);
          else if (sel < 3) line_q.push_back(hhfr_pkg::ChMinus);
          repeat ($urandom_range(12)) begin
            line_q.push_back(hhfr_pkg::ChZero + 8'($urandom_range(9)));
          end
          if ($urandom_range(3) == 0) push_text(" ;x");
        end else begin
          repeat ($urandom_range(30)) line_q.push_back(8'($urandom_range(32, 126)));
        end
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(1, 4)) line_q.push_back(8'($urandom_range(128, 255)));
        end
        sel = $urandom_range(19);
        if (sel < 14) push_text("\r\n");
        else if (sel < 19) push_text("\n");
        else fin_now = 1'b1;
      end else if (pick < 80) begin
        // Damaged name: one character replaced, or the name cut short mid-line.
        push_name(k, 1);
        if ($urandom_range(1) == 1) begin
          line_q[$urandom_range(hdr_text[k].len() - 1)] = 8'($urandom_range(32, 126));
        end else begin
          cut = $urandom_range(1, hdr_text[k].len() - 1);
          while (line_q.size() > cut) void'(line_q.pop_back());
        end
        repeat ($urandom_range(10)) line_q.push_back(8'($urandom_range(32, 126)));
        push_text("\r\n");
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 30)) line_q.push_back(8'($urandom_range(255)));
        line_q.push_back(hhfr_pkg::ChLf);
      end else begin
        // The block ends somewhere inside a name or on its last character.
        push_name(k, 1);
        cut = $urandom_range(1, hdr_text[k].len());
        while (line_q.size() > cut) void'(line_q.pop_back());
        fin_now = 1'b1;
      end
      send_line(fin_now);
    end
    calm = 1'b0;
  endtask

  task automatic check_field(input string what, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_v, got_v);
      failures++;
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 17);
  end

  // Output signals change only at the rising edge, so the values seen at the falling
  // edge are the ones that the next rising edge takes.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_fields.size() == 0) begin
        $display("%0t: result with no word pending, expected none, got header_id %0d",
                 $time, header_id_o);
        failures++;
      end else begin
        want = pending_fields.pop_front();
        check_field("header_id", 32'(want.hdr), 32'(header_id_o));
        check_field("value_start", 32'(want.start), 32'(value_start_o));
        check_field("value_length", 32'(want.len), 32'(value_length_o));
        check_field("number_value", want.num, number_value_o);
        check_field("number_valid", 32'(want.num_ok), 32'(number_valid_o));
        check_field("number_saturated", 32'(want.sat), 32'(number_saturated_o));
      end
    end
  end

  initial begin
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    byte_in_i    <= 8'h00;
    final_byte_i <= 1'b0;
    calm          = 1'b0;
    failures      = 0;
    bytes_sent    = 0;
    clear_block();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_each_name();
    test_number_parse();
    test_line_cases();
    test_random_blocks(1100);

    in_valid_i <= 1'b0;
    while (pending_fields.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
